[rtl/sssm_pkg.sv]
// Shared types, constants and register codes for the strip sharing merge block.
package sssm_pkg;

  localparam int ENERGY_BITS  = 16;
  localparam int SUM_BITS     = ENERGY_BITS + 2;  // three strips summed at full precision
  localparam int CFG_IDX_BITS = 2;

  typedef logic [1:0]             status_t;
  typedef logic [ENERGY_BITS-1:0] energy_t;
  typedef logic [SUM_BITS-1:0]    sum_t;

  localparam status_t ST_NONE   = 2'd0;
  localparam status_t ST_CAND   = 2'd1;
  localparam status_t ST_MERGED = 2'd2;
  localparam status_t ST_INTO   = 2'd3;

  localparam logic [CFG_IDX_BITS-1:0] REG_LOW_CUT    = 2'd0;
  localparam logic [CFG_IDX_BITS-1:0] REG_MAX_SIGNAL = 2'd1;
  localparam logic [CFG_IDX_BITS-1:0] REG_LOW_FLUX   = 2'd2;
  localparam logic [CFG_IDX_BITS-1:0] REG_ZERO_BELOW = 2'd3;

  localparam energy_t MAX_SIGNAL_RST = energy_t'(5120);  // 20.0 in Q8.8

  typedef struct packed {
    energy_t low_cut;
    energy_t max_signal;
    logic    low_flux_mode;
    logic    zero_below;
  } cfg_t;

  typedef struct packed {
    energy_t this_energy;
    logic    this_invalid;
    energy_t next_energy;
    logic    next_invalid;
    energy_t high_cut;
    logic    first_strip;
    logic    last_strip;
  } strip_t;

endpackage

[rtl/strip_signal_sharing_merge.sv]
// Top level of the strip sharing merge: input stage, merge logic, result register.
// The path runs through the input register, then the result register.
// Throughput: one strip per cycle unless out_tready stalls the result register;
// the neighbor state updates as a strip leaves the input stage.
// Reset (rst_n low, synchronous): both stages empty, cuts to low 0 / max 20.0, modes off,
// neighbor state at sector start (previous energy 0, status none, next status candidate).
// in_tready follows out_tready combinationally when both stages are full.
module strip_signal_sharing_merge
  import sssm_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst_n,
  // strip input
  input  logic                    in_tvalid,
  output logic                    in_tready,
  input  logic [47:0]             in_tdata,   // this_energy, next_energy, high_cut
  input  logic [2:0]              in_tuser,   // this_invalid, next_invalid, first_strip
  input  logic                    in_tlast,   // last_strip
  // merged result
  output logic                    out_tvalid,
  input  logic                    out_tready,
  output logic [15:0]             out_tdata,  // merged_energy
  output logic                    out_tuser,  // out_invalid
  // register writes
  input  logic                    cfg_valid,
  output logic                    cfg_ready,
  input  logic [CFG_IDX_BITS-1:0] cfg_index,
  input  logic [ENERGY_BITS-1:0]  cfg_data
);

  cfg_t    cfg;
  strip_t  in_item;
  strip_t  s1_item_r;
  logic    s1_valid_r;
  logic    out_valid_r;
  energy_t out_energy_r;
  logic    out_invalid_r;
  energy_t mg_energy;
  logic    mg_invalid;
  logic    adv;
  logic    in_acc;

  // Writes always taken; software must write only while the block is idle, unenforced.
  assign cfg_ready = 1'b1;

  sssm_cfg_regs u_cfg (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (cfg_valid),
    .wr_index (cfg_index),
    .wr_data  (cfg_data),
    .cfg      (cfg)
  );

  // Unpack the stream item.
  always_comb begin
    in_item.this_energy  = in_tdata[15:0];
    in_item.next_energy  = in_tdata[31:16];
    in_item.high_cut     = in_tdata[47:32];
    in_item.this_invalid = in_tuser[0];
    in_item.next_invalid = in_tuser[1];
    in_item.first_strip  = in_tuser[2];
    in_item.last_strip   = in_tlast;
  end

  // Input stage moves on when the result register is free or being drained.
  assign adv       = s1_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !s1_valid_r || adv;
  assign in_acc    = in_tvalid && in_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_tready) begin
      s1_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_item_r <= in_item;
    end
  end

  sssm_merge u_merge (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg           (cfg),
    .item          (s1_item_r),
    .adv           (adv),
    .merged_energy (mg_energy),
    .out_invalid   (mg_invalid)
  );

  // Result register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_energy_r  <= mg_energy;
      out_invalid_r <= mg_invalid;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_energy_r;
  assign out_tuser  = out_invalid_r;

  // a dead strip always delivers zero energy
  a_dead_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_invalid_r |-> out_energy_r == '0)
    else $error("dead strip carries energy");

  // a held strip stays in the input stage
  a_s1_hold: assert property (@(posedge clk) disable iff (!rst_n)
    s1_valid_r && !adv |=> s1_valid_r && $stable(s1_item_r))
    else $error("input stage lost a stalled item");

  // the result register is refilled only by a strip leaving the input stage
  a_out_src: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(adv))
    else $error("result appeared without a strip");

endmodule

[rtl/sssm_cfg_regs.sv]
// Configuration register file: cut levels and mode bits.
module sssm_cfg_regs
  import sssm_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    wr_en,
  input  logic [CFG_IDX_BITS-1:0] wr_index,
  input  logic [ENERGY_BITS-1:0]  wr_data,
  output cfg_t                    cfg
);

  cfg_t cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.low_cut       <= '0;
      cfg_r.max_signal    <= MAX_SIGNAL_RST;
      cfg_r.low_flux_mode <= 1'b0;
      cfg_r.zero_below    <= 1'b0;
    end else if (wr_en) begin
      case (wr_index)
        REG_LOW_CUT:    cfg_r.low_cut       <= wr_data;
        REG_MAX_SIGNAL: cfg_r.max_signal    <= wr_data;
        REG_LOW_FLUX:   cfg_r.low_flux_mode <= wr_data[0];
        REG_ZERO_BELOW: cfg_r.zero_below    <= wr_data[0];
        default: ;
      endcase
    end
  end

  assign cfg = cfg_r;

endmodule

[rtl/sssm_merge.sv]
// Sharing merge decision for one strip plus the neighbor state it carries along.
module sssm_merge
  import sssm_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  cfg_t    cfg,
  input  strip_t  item,
  input  logic    adv,            // item leaves the input stage this cycle
  output energy_t merged_energy,
  output logic    out_invalid
);

  energy_t prev_energy_r, prev_energy_nxt;
  status_t prev_status_r, prev_status_nxt;
  status_t cur_status_r,  cur_status_nxt;

  always_comb begin
    energy_t e, ne, pe, hc, lc;
    status_t ps, ts, ns;
    sum_t    total, result;
    logic    inv;

    e     = item.this_energy;
    inv   = item.this_invalid;
    hc    = item.high_cut;
    lc    = cfg.low_cut;
    ne    = (item.last_strip || item.next_invalid) ? '0 : item.next_energy;
    pe    = item.first_strip ? '0 : prev_energy_r;
    ps    = item.first_strip ? ST_NONE : prev_status_r;
    ts    = item.first_strip ? ST_CAND : cur_status_r;
    ns    = item.last_strip ? ST_NONE : ST_CAND;
    total = '0;
    result = '0;

    if (inv || e == '0) begin
      ts = ST_NONE;
      ns = ST_CAND;
    end else if (e < lc || e > cfg.max_signal) begin
      ts = ST_NONE;
    end else if (ts == ST_MERGED) begin
      result = '0;
    end else if (hc == '0) begin
      ts = ST_NONE;
    end else if (cfg.low_flux_mode && e < ne && ne > hc) begin
      ts = ST_CAND;
      ns = ST_CAND;
    end else begin
      total = sum_t'(e);
      if (ps == ST_CAND && pe > lc && pe < hc)
        total = total + sum_t'(pe);
      if (ne > lc && ne < hc) begin
        total = total + sum_t'(ne);
        ns    = ST_MERGED;
      end
      if (total > sum_t'(hc)) begin
        ts     = (total > sum_t'(e)) ? ST_INTO : ST_NONE;
        result = total;
      end else begin
        ns = ST_CAND;
        if (total < sum_t'(lc)) begin
          ts = ST_NONE;
        end else begin
          ts     = ST_CAND;
          result = cfg.zero_below ? '0 : total;
        end
      end
    end

    // saturate only the delivered value
    if (inv)
      merged_energy = '0;
    else if (result[SUM_BITS-1:ENERGY_BITS] != '0)
      merged_energy = '1;
    else
      merged_energy = result[ENERGY_BITS-1:0];
    out_invalid = inv;

    if (item.last_strip) begin
      prev_energy_nxt = '0;
      prev_status_nxt = ST_NONE;
      cur_status_nxt  = ST_CAND;
    end else begin
      prev_energy_nxt = inv ? '0 : e;
      prev_status_nxt = ts;
      cur_status_nxt  = ns;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_energy_r <= '0;
      prev_status_r <= ST_NONE;
      cur_status_r  <= ST_CAND;
    end else if (adv) begin
      prev_energy_r <= prev_energy_nxt;
      prev_status_r <= prev_status_nxt;
      cur_status_r  <= cur_status_nxt;
    end
  end

  // a sector end puts the neighbor state back to its start values
  a_last_resets: assert property (@(posedge clk) disable iff (!rst_n)
    adv && item.last_strip |=>
      prev_energy_r == '0 && prev_status_r == ST_NONE && cur_status_r == ST_CAND)
    else $error("neighbor state not cleared after last strip");

  // a dead strip never serves as an energy donor
  a_dead_prev: assert property (@(posedge clk) disable iff (!rst_n)
    adv && item.this_invalid |=> prev_energy_r == '0)
    else $error("dead strip left energy in neighbor state");

endmodule

[tb/sv/tb_strip_signal_sharing_merge.sv]
// Self-checking testbench for strip_signal_sharing_merge: directed and random strip items.
module tb_strip_signal_sharing_merge;
  import sssm_pkg::*;

  // One expected merged item, as it should leave on the result stream.
  typedef struct packed {
    energy_t energy;
    logic    invalid;
  } merged_t;

  // Clock, reset and every block input start at known values.
  logic                    clk        = 1'b0;
  logic                    rst_n      = 1'b0;
  logic                    in_tvalid  = 1'b0;
  logic                    in_tready;
  logic [47:0]             in_tdata   = '0;  // this_energy, next_energy, high_cut
  logic [2:0]              in_tuser   = '0;  // this_invalid, next_invalid, first_strip
  logic                    in_tlast   = 1'b0;  // last_strip
  logic                    out_tvalid;
  logic                    out_tready = 1'b0;
  logic [15:0]             out_tdata;  // merged_energy
  logic                    out_tuser;  // out_invalid
  logic                    cfg_valid  = 1'b0;
  logic                    cfg_ready;
  logic [CFG_IDX_BITS-1:0] cfg_index  = REG_LOW_CUT;
  logic [ENERGY_BITS-1:0]  cfg_data   = '0;

  // Pending strips, the strip currently on the bus, and merged results still owed.
  strip_t  strip_q[$];
  strip_t  strip_on_bus = '0;
  bit      strip_busy = 1'b0;  // an item sits on the input bus, not yet taken
  merged_t merged_q[$];
  int      strips_queued = 0;
  int      mismatches = 0;

  // Idle rates in percent for the two stream sides.
  int send_idle_pct = 0;
  int recv_stall_pct = 0;

  // Shadow of the block's registers and neighbor state.
  cfg_t    cfg_shadow = '{low_cut: '0, max_signal: MAX_SIGNAL_RST,
                          low_flux_mode: 1'b0, zero_below: 1'b0};
  energy_t prev_e    = '0;       // raw energy of the previous strip
  status_t prev_st   = ST_NONE;  // sharing status of the previous strip
  status_t coming_st = ST_CAND;  // status already assigned to the strip about to arrive

  strip_signal_sharing_merge dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .in_tlast  (in_tlast),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  function automatic void sector_start();
    prev_e    = '0;
    prev_st   = ST_NONE;
    coming_st = ST_CAND;
  endfunction

  // Merged energy of one strip; advances the neighbor state as the block does.
  function automatic merged_t merge_strip(strip_t s);
    energy_t e, ne, hc, lc;
    status_t ts, ns;
    sum_t    total, res;
    merged_t r;
    if (s.first_strip) sector_start();
    e  = s.this_energy;
    hc = s.high_cut;
    lc = cfg_shadow.low_cut;
    // no right neighbor on the last strip; a dead one counts as empty
    ne = (s.last_strip || s.next_invalid) ? '0 : s.next_energy;
    ts = coming_st;
    ns = s.last_strip ? ST_NONE : ST_CAND;
    res = '0;
    if (s.this_invalid || e == '0) begin
      // dead or empty strip: nothing to share, next strip stays open
      ts = ST_NONE;
      ns = ST_CAND;
    end else if (e < lc || e > cfg_shadow.max_signal) begin
      ts = ST_NONE;
    end else if (ts == ST_MERGED) begin
      res = '0;  // energy already given to the left neighbor
    end else if (hc == '0) begin
      ts = ST_NONE;  // no fit for this strip
    end else if (cfg_shadow.low_flux_mode && e < ne && ne > hc) begin
      // smaller strip before a larger one: leave it to the larger
      ts = ST_CAND;
      ns = ST_CAND;
    end else begin
      total = sum_t'(e);
      if (prev_st == ST_CAND && prev_e > lc && prev_e < hc) total = total + sum_t'(prev_e);
      if (ne > lc && ne < hc) begin
        total = total + sum_t'(ne);
        ns = ST_MERGED;
      end
      if (total > sum_t'(hc)) begin
        ts  = (total > sum_t'(e)) ? ST_INTO : ST_NONE;
        res = total;
      end else begin
        ns = ST_CAND;
        if (total < sum_t'(lc)) begin
          ts = ST_NONE;
        end else begin
          ts  = ST_CAND;
          res = cfg_shadow.zero_below ? '0 : total;
        end
      end
    end
    r.invalid = s.this_invalid;
    // sums are compared at full width; only the output saturates
    if (s.this_invalid) r.energy = '0;
    else if (res > sum_t'({ENERGY_BITS{1'b1}})) r.energy = '1;
    else r.energy = energy_t'(res);
    if (s.last_strip) begin
      sector_start();
    end else begin
      prev_e    = s.this_invalid ? '0 : e;
      prev_st   = ts;
      coming_st = ns;
    end
    return r;
  endfunction

  // Input driver: offers the next pending item when the bus slot frees up, unless a random sender gap holds it back.
  always @(posedge clk) begin : strip_drive
    strip_t s;
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else begin
      if (in_tvalid && in_tready) begin
        merged_q.push_back(merge_strip(strip_on_bus));
        strip_busy = 1'b0;
      end
      if (!in_tvalid || in_tready) begin
        if (strip_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          s = strip_q.pop_front();
          strip_busy = 1'b1;
          strip_on_bus <= s;
          in_tdata  <= {s.high_cut, s.next_energy, s.this_energy};
          in_tuser  <= {s.first_strip, s.next_invalid, s.this_invalid};
          in_tlast  <= s.last_strip;
          in_tvalid <= 1'b1;
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // Result monitor: each accepted item against the oldest expectation.
  always @(posedge clk) begin : result_check
    merged_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (merged_q.size() == 0) begin
        $display("%0t: unexpected item, got energy %h invalid %b",
                 $time, out_tdata, out_tuser);
        mismatches++;
      end else begin
        want = merged_q.pop_front();
        if (out_tdata !== want.energy) begin
          $display("%0t: merged_energy expected %h got %h", $time, want.energy, out_tdata);
          mismatches++;
        end
        if (out_tuser !== want.invalid) begin
          $display("%0t: out_invalid expected %b got %b", $time, want.invalid, out_tuser);
          mismatches++;
        end
      end
    end
    out_tready <= (recv_stall_pct == 0) ? 1'b1 : ($urandom_range(99) >= recv_stall_pct);
  end

  task automatic push_strip(energy_t e, bit inv, energy_t ne, bit ninv, energy_t hc,
                            bit first, bit last);
    strip_t s;
    s.this_energy  = e;
    s.this_invalid = inv;
    s.next_energy  = ne;
    s.next_invalid = ninv;
    s.high_cut     = hc;
    s.first_strip  = first;
    s.last_strip   = last;
    strip_q.push_back(s);
    strips_queued++;
  endtask

  // Energies mixed from zero, full scale, random and values near the cuts, so sharing decisions flip often.
  function automatic energy_t rand_energy(energy_t lc, energy_t cut);
    case ($urandom_range(11))
      0:       return '0;
      1:       return energy_t'($urandom);
      2:       return energy_t'(16'hFFFF - $urandom_range(2));
      3:       return energy_t'(lc + $urandom_range(4) - 2);
      4:       return energy_t'(cut + $urandom_range(4) - 2);
      5, 6:    return energy_t'($urandom_range(cut));
      default: return energy_t'($urandom_range(40, 900));
    endcase
  endfunction

  function automatic energy_t rand_cut(energy_t cut);
    case ($urandom_range(15))
      0:       return '0;
      1:       return energy_t'($urandom);
      default: return energy_t'(cut + $urandom_range(64) - 32);
    endcase
  endfunction

  // One sector in order; next_energy mirrors the following strip. Some are broken.
  task automatic push_sector();
    int      n, k;
    energy_t cut, ne;
    bit      ninv, drop_first, drop_last, scramble;
    energy_t en[$];
    bit      dead[$];
    n   = ($urandom_range(9) == 0) ? $urandom_range(11, 30) : $urandom_range(1, 10);
    cut = ($urandom_range(3) == 0) ? energy_t'($urandom_range(20000, 65535))
                                   : energy_t'($urandom_range(300, 1200));
    for (k = 0; k < n; k++) begin
      en.push_back(rand_energy(cfg_shadow.low_cut, cut));
      dead.push_back($urandom_range(15) == 0);
    end
    scramble   = ($urandom_range(7) == 0);
    drop_first = ($urandom_range(11) == 0);
    drop_last  = ($urandom_range(11) == 0);
    for (k = 0; k < n; k++) begin
      ne   = (k < n - 1) ? en[k + 1] : energy_t'($urandom);
      ninv = (k < n - 1) ? dead[k + 1] : bit'($urandom_range(1));
      if (scramble && $urandom_range(2) == 0) ne = energy_t'($urandom);
      push_strip(en[k], dead[k], ne, ninv, rand_cut(cut),
                 (k == 0) && !drop_first, (k == n - 1) && !drop_last);
    end
  endtask

  task automatic write_reg(logic [CFG_IDX_BITS-1:0] idx, energy_t val);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (idx)
      REG_LOW_CUT:    cfg_shadow.low_cut       = val;
      REG_MAX_SIGNAL: cfg_shadow.max_signal    = val;
      REG_LOW_FLUX:   cfg_shadow.low_flux_mode = val[0];
      REG_ZERO_BELOW: cfg_shadow.zero_below    = val[0];
      default: ;
    endcase
  endtask

  task automatic load_config(energy_t lc, energy_t mx, bit lf, bit zb);
    write_reg(REG_LOW_CUT, lc);
    write_reg(REG_MAX_SIGNAL, mx);
    write_reg(REG_LOW_FLUX, energy_t'(lf));
    write_reg(REG_ZERO_BELOW, energy_t'(zb));
  endtask

  // Wait for every pending item to go in and every result to come out,
  // then let the pipeline settle.
  task automatic drain();
    while (strip_q.size() != 0 || strip_busy || merged_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  initial begin : run
    int ph, start_count;
    bit paused;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    for (ph = 0; ph < 8; ph++) begin
      // idle pattern rotates: none, sender gaps, receiver stalls, both lightly
      case (ph % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 53; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 53; end
        default: begin send_idle_pct = 16; recv_stall_pct = 16; end
      endcase
      case (ph)
        0: begin
          load_config(16'd0, MAX_SIGNAL_RST, 1'b0, 1'b0);
          // empty first strip, then a two-strip share into the larger one
          push_strip(16'd0, 0, 16'd300, 0, 16'd400, 1, 0);
          push_strip(16'd300, 0, 16'd100, 0, 16'd350, 0, 0);
          push_strip(16'd100, 0, 16'd0, 0, 16'd350, 0, 0);
          push_strip(16'd0, 0, 16'd0, 0, 16'd350, 0, 0);
          // dead strip with full-scale energy, then a dead right neighbor
          push_strip(16'hFFFF, 1, 16'd0, 0, 16'd350, 0, 0);
          push_strip(16'd200, 0, 16'd150, 1, 16'd350, 0, 0);
          // no fit, and above the signal ceiling
          push_strip(16'd150, 0, 16'hFFFF, 0, 16'd0, 0, 0);
          push_strip(16'd6000, 0, 16'd100, 0, 16'd400, 0, 0);
          // sum past full scale saturates; the donor follows as zero
          push_strip(16'd5120, 0, 16'd62000, 0, 16'hFFFF, 0, 0);
          push_strip(16'd62000, 0, 16'd100, 0, 16'hFFFF, 0, 0);
          // last strip ignores its next fields
          push_strip(16'd300, 0, 16'hFFFF, 1, 16'd500, 0, 1);
          push_strip(16'd400, 0, 16'hAAAA, 0, 16'd500, 1, 1);
          // three strips summed into the middle one
          push_strip(16'd150, 0, 16'd200, 0, 16'd180, 1, 0);
          push_strip(16'd200, 0, 16'd120, 0, 16'd400, 0, 0);
          push_strip(16'd120, 0, 16'd300, 0, 16'd400, 0, 1);
          // sector closed by the last strip without a first flag after it
          push_strip(16'd500, 0, 16'd0, 0, 16'd600, 0, 1);
        end
        1: begin
          load_config(16'd256, MAX_SIGNAL_RST, 1'b1, 1'b1);
          // low-flux: small strip before a large one yields to it
          push_strip(16'd300, 0, 16'd2000, 0, 16'd1000, 1, 0);
          push_strip(16'd2000, 0, 16'd300, 0, 16'd1000, 0, 0);
          push_strip(16'd300, 0, 16'd0, 0, 16'd1000, 0, 0);
          // below the low cut
          push_strip(16'd100, 0, 16'd0, 0, 16'd1000, 0, 0);
          // between the cuts: zeroed by zero_below
          push_strip(16'd400, 0, 16'd0, 0, 16'd1000, 0, 1);
          push_strip(16'd256, 0, 16'd256, 0, 16'd1000, 1, 1);
        end
        2: load_config(16'd64, 16'hFFFF, 1'b0, 1'b1);
        3: load_config(16'hFFFF, 16'd0, 1'b1, 1'b1);
        4: load_config(16'd0, 16'hFFFF, 1'b1, 1'b0);
        5: load_config(16'd200, 16'd3000, 1'b0, 1'b0);
        6: load_config(16'hFFFF, 16'hFFFF, 1'b0, 1'b0);
        default: load_config(16'd100, 16'd1500, 1'b1, 1'b0);
      endcase
      // random part: mostly whole sectors, some bursts of loose items
      start_count = strips_queued;
      paused = 1'b0;
      while (strips_queued - start_count < 160) begin
        if (ph == 2 && !paused && strips_queued - start_count >= 80) begin
          drain();  // sender holds off until the pipe is empty
          paused = 1'b1;
        end
        if ($urandom_range(5) != 0) begin
          push_sector();
        end else begin
          repeat ($urandom_range(1, 4))
            push_strip(energy_t'($urandom), bit'($urandom_range(1)), energy_t'($urandom),
                       bit'($urandom_range(1)), energy_t'($urandom),
                       bit'($urandom_range(1)), bit'($urandom_range(1)));
        end
      end
      drain();
    end
    if (mismatches == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest legal run.
  initial begin
    #(12 * 500000);
    $display("*** FAILED ***");
    $finish;
  end

endmodule
